// ===== src/selective_repeat_arq_window_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Selective-repeat ARQ window unit: assertion macros
// Shared assertion forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_ARQ_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_ARQ_WINDOW_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SRARQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srarq: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SRARQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srarq: next-cycle check failed");

`endif

// ===== src/srarq_pkg.sv =====
// ----------------------------------------------------------------------------
// srarq_pkg
// Types, codes and control/status bundles of the selective-repeat ARQ window
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srarq_pkg;

  // Event codes
  localparam logic [2:0] ACT_PKT_READY  = 3'd0;
  localparam logic [2:0] ACT_PHYS_READY = 3'd1;
  localparam logic [2:0] ACT_FRAME_RX   = 3'd2;
  localparam logic [2:0] ACT_DATA_TMO   = 3'd3;
  localparam logic [2:0] ACT_ACK_TMO    = 3'd4;

  // Received frame kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // Link commands
  localparam logic [3:0] CMD_SEND      = 4'd0;
  localparam logic [3:0] CMD_RESEND    = 4'd1;
  localparam logic [3:0] CMD_SEND_ACK  = 4'd2;
  localparam logic [3:0] CMD_SEND_NAK  = 4'd3;
  localparam logic [3:0] CMD_STORE     = 4'd4;
  localparam logic [3:0] CMD_DELIVER   = 4'd5;
  localparam logic [3:0] CMD_STOP_TMR  = 4'd6;
  localparam logic [3:0] CMD_START_ACK = 4'd7;
  localparam logic [3:0] CMD_NONE      = 4'd8;

  // Result queue per item
  localparam int MAX_RESULTS = 10;
  localparam int CNT_W       = 4;

  // Input beat
  typedef struct packed {
    logic [2:0] action;
    logic       frame_ok;
    logic [1:0] frame_kind;
    logic [2:0] frame_seq;
    logic [2:0] ack_num;
    logic [2:0] timeout_seq;
  } req_t;

  // Output beat
  typedef struct packed {
    logic [3:0] command;
    logic [2:0] seq_out;
    logic [2:0] ack_out;
    logic [1:0] slot;
    logic       network_enable;
    logic       last;
  } rsp_t;

  // One queued command, before the per-item flags are attached
  typedef struct packed {
    logic [3:0] command;
    logic [2:0] seq_out;
    logic [2:0] ack_out;
    logic [1:0] slot;
  } entry_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_PKT,
    OP_PHYS,
    OP_BAD_FRAME,
    OP_RX_HEAD,
    OP_STORE,
    OP_DELIVER,
    OP_NAK_RESEND,
    OP_ACK_STEP,
    OP_DATA_TMO,
    OP_ACK_TMO,
    OP_PAD,
    OP_LOAD
  } op_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RX_HEAD,
    S_STORE,
    S_DELIVER,
    S_NAK_RESEND,
    S_ACK,
    S_PAD,
    S_LOAD,
    S_DRAIN
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       frame_ok;
    logic [1:0] frame_kind;
    logic       store_ok;
    logic       deliver_more;
    logic       ack_more;
    logic       more;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/srarq_dpath.sv =====
// ----------------------------------------------------------------------------
// srarq_dpath
// Window registers, arrived bitmap, per-item result queue and output register.
// Executes one operation per cycle as told by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_arq_window_unit_macros.svh"

module srarq_dpath
  import srarq_pkg::*;
#(
  parameter int SEQ_W = 3
) (
  input  wire      clk,
  input  wire      rst,
  input  req_t     req,
  input  dp_cmd_t  ctl,
  output dp_stat_t stat,
  output rsp_t     rsp
);

  localparam int SB = SEQ_W;
  localparam int NB = 1 << (SEQ_W - 1);
  localparam int SW = SEQ_W - 1;

  // Window state
  logic [SB-1:0] send_lower, send_lower_next;
  logic [SB-1:0] next_to_send, next_to_send_next;
  logic [SB-1:0] buffered_count, buffered_count_next;
  logic [SB-1:0] recv_lower, recv_lower_next;
  logic [SB-1:0] recv_upper, recv_upper_next;
  logic [NB-1:0] slot_arrived, slot_arrived_next;
  logic          nak_allowed, nak_allowed_next;
  logic          phys_ready, phys_ready_next;

  // Captured item
  logic [2:0]    it_action;
  logic          it_ok;
  logic [1:0]    it_kind;
  logic [SB-1:0] it_seq;
  logic [SB-1:0] it_ack;
  logic [SB-1:0] it_tseq;

  // Result queue
  entry_t           queue [MAX_RESULTS];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] rd;
  logic             emit_en;
  entry_t           emit_ent;
  rsp_t             out_q;

  logic [SB-1:0] ack_val;
  logic [SB-1:0] nak_t;
  logic          net_en;

  function automatic logic [2:0] to3(input logic [SB-1:0] v);
    logic [SB+2:0] w;
    w = {3'b000, v};
    return w[2:0];
  endfunction

  function automatic logic [1:0] slot2(input logic [SB-1:0] v);
    logic [SW+1:0] w;
    w = {2'b00, v[SW-1:0]};
    return w[1:0];
  endfunction

  function automatic logic [SB-1:0] from3(input logic [2:0] v);
    logic [SB+2:0] w;
    w = {{SB{1'b0}}, v};
    return w[SB-1:0];
  endfunction

  // a <= b < c, circularly
  function automatic logic in_window(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                     input logic [SB-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  assign ack_val = recv_lower + {SB{1'b1}};
  assign nak_t   = it_ack + SB'(1);
  assign net_en  = (buffered_count < SB'(NB)) && phys_ready;

  // Status to controller
  always_comb begin
    stat.action       = it_action;
    stat.frame_ok     = it_ok;
    stat.frame_kind   = it_kind;
    stat.store_ok     = in_window(recv_lower, it_seq, recv_upper) &&
                        !slot_arrived[it_seq[SW-1:0]];
    stat.deliver_more = slot_arrived[recv_lower[SW-1:0]];
    stat.ack_more     = in_window(send_lower, it_ack, next_to_send);
    stat.more         = (rd != cnt);
  end

  // Operation: state update and the command it emits
  always_comb begin
    send_lower_next     = send_lower;
    next_to_send_next   = next_to_send;
    buffered_count_next = buffered_count;
    recv_lower_next     = recv_lower;
    recv_upper_next     = recv_upper;
    slot_arrived_next   = slot_arrived;
    nak_allowed_next    = nak_allowed;
    phys_ready_next     = phys_ready;
    emit_en             = 1'b0;
    emit_ent            = '{command: CMD_NONE, seq_out: 3'd0, ack_out: 3'd0, slot: 2'd0};
    case (ctl.op)
      OP_PKT: begin
        if (buffered_count < SB'(NB)) begin
          buffered_count_next = buffered_count + SB'(1);
          emit_en   = 1'b1;
          emit_ent  = '{command: CMD_SEND, seq_out: to3(next_to_send),
                        ack_out: to3(ack_val), slot: slot2(next_to_send)};
          phys_ready_next   = 1'b0;
          next_to_send_next = next_to_send + SB'(1);
        end
      end
      OP_PHYS: begin
        phys_ready_next = 1'b1;
      end
      OP_BAD_FRAME: begin
        if (nak_allowed) begin
          emit_en  = 1'b1;
          emit_ent = '{command: CMD_SEND_NAK, seq_out: 3'd0, ack_out: to3(ack_val),
                       slot: 2'd0};
          phys_ready_next  = 1'b0;
          nak_allowed_next = 1'b0;
        end
      end
      OP_RX_HEAD: begin
        emit_en = 1'b1;
        if ((it_seq != recv_lower) && nak_allowed) begin
          emit_ent = '{command: CMD_SEND_NAK, seq_out: 3'd0, ack_out: to3(ack_val),
                       slot: 2'd0};
          phys_ready_next  = 1'b0;
          nak_allowed_next = 1'b0;
        end else begin
          emit_ent = '{command: CMD_START_ACK, seq_out: 3'd0, ack_out: 3'd0, slot: 2'd0};
        end
      end
      OP_STORE: begin
        slot_arrived_next[it_seq[SW-1:0]] = 1'b1;
        emit_en  = 1'b1;
        emit_ent = '{command: CMD_STORE, seq_out: 3'd0, ack_out: 3'd0,
                     slot: slot2(it_seq)};
      end
      OP_DELIVER: begin
        emit_en  = 1'b1;
        emit_ent = '{command: CMD_DELIVER, seq_out: 3'd0, ack_out: 3'd0,
                     slot: slot2(recv_lower)};
        nak_allowed_next = 1'b1;
        slot_arrived_next[recv_lower[SW-1:0]] = 1'b0;
        recv_lower_next = recv_lower + SB'(1);
        recv_upper_next = recv_upper + SB'(1);
      end
      OP_NAK_RESEND: begin
        if (in_window(send_lower, nak_t, next_to_send)) begin
          emit_en  = 1'b1;
          emit_ent = '{command: CMD_RESEND, seq_out: to3(nak_t), ack_out: to3(ack_val),
                       slot: slot2(nak_t)};
          phys_ready_next = 1'b0;
        end
      end
      OP_ACK_STEP: begin
        if (buffered_count != '0) begin
          buffered_count_next = buffered_count - SB'(1);
        end
        emit_en  = 1'b1;
        emit_ent = '{command: CMD_STOP_TMR, seq_out: to3(send_lower), ack_out: 3'd0,
                     slot: 2'd0};
        send_lower_next = send_lower + SB'(1);
      end
      OP_DATA_TMO: begin
        emit_en  = 1'b1;
        emit_ent = '{command: CMD_RESEND, seq_out: to3(it_tseq), ack_out: to3(ack_val),
                     slot: slot2(it_tseq)};
        phys_ready_next = 1'b0;
      end
      OP_ACK_TMO: begin
        emit_en  = 1'b1;
        emit_ent = '{command: CMD_SEND_ACK, seq_out: 3'd0, ack_out: to3(ack_val),
                     slot: 2'd0};
        phys_ready_next = 1'b0;
      end
      OP_PAD: begin
        emit_en = (cnt == '0);
      end
      default: begin
      end
    endcase
  end

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      send_lower     <= '0;
      next_to_send   <= '0;
      buffered_count <= '0;
      recv_lower     <= '0;
      recv_upper     <= SB'(NB);
      slot_arrived   <= '0;
      nak_allowed    <= 1'b1;
      phys_ready     <= 1'b0;
    end else begin
      send_lower     <= send_lower_next;
      next_to_send   <= next_to_send_next;
      buffered_count <= buffered_count_next;
      recv_lower     <= recv_lower_next;
      recv_upper     <= recv_upper_next;
      slot_arrived   <= slot_arrived_next;
      nak_allowed    <= nak_allowed_next;
      phys_ready     <= phys_ready_next;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LATCH) begin
      it_action <= req.action;
      it_ok     <= req.frame_ok;
      it_kind   <= req.frame_kind;
      it_seq    <= from3(req.frame_seq);
      it_ack    <= from3(req.ack_num);
      it_tseq   <= from3(req.timeout_seq);
    end
  end

  // Queue pointers; commands past the cap are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (ctl.op == OP_LATCH) begin
      cnt <= '0;
      rd  <= '0;
    end else begin
      if (emit_en && (cnt < CNT_W'(MAX_RESULTS))) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (ctl.op == OP_LOAD) begin
        rd <= rd + CNT_W'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (emit_en && (cnt < CNT_W'(MAX_RESULTS))) begin
      queue[cnt] <= emit_ent;
    end
  end

  // Output register; window state is final once loading starts
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD) begin
      out_q.command        <= queue[rd].command;
      out_q.seq_out        <= queue[rd].seq_out;
      out_q.ack_out        <= queue[rd].ack_out;
      out_q.slot           <= queue[rd].slot;
      out_q.network_enable <= net_en;
      out_q.last           <= ((rd + CNT_W'(1)) == cnt);
    end
  end

  assign rsp = out_q;

  `SRARQ_ASSERT_NOW(a_rx_span, 1'b1, (recv_upper - recv_lower) == SB'(NB))
  `SRARQ_ASSERT_NOW(a_buf_cap, 1'b1, buffered_count <= SB'(NB))
  `SRARQ_ASSERT_NOW(a_load_nonempty, ctl.op == OP_LOAD, rd != cnt)
  `SRARQ_ASSERT_NEXT(a_pad_fills, ctl.op == OP_PAD, cnt != '0)

endmodule

`default_nettype wire

// ===== src/srarq_ctrl.sv =====
// ----------------------------------------------------------------------------
// srarq_ctrl
// Sequencer: takes one event, steps the datapath through its operations and
// window loops, then drains the queued commands one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_arq_window_unit_macros.svh"

module srarq_ctrl
  import srarq_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  wire      rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if ((stat.action == ACT_FRAME_RX) && stat.frame_ok) begin
          if (stat.frame_kind == KIND_DATA) begin
            state_next = S_RX_HEAD;
          end else if (stat.frame_kind == KIND_NAK) begin
            state_next = S_NAK_RESEND;
          end else begin
            state_next = S_ACK;
          end
        end else begin
          state_next = S_PAD;
        end
      end
      S_RX_HEAD: begin
        state_next = stat.store_ok ? S_STORE : S_ACK;
      end
      S_STORE: begin
        state_next = S_DELIVER;
      end
      S_DELIVER: begin
        if (!stat.deliver_more) state_next = S_ACK;
      end
      S_NAK_RESEND: begin
        state_next = S_ACK;
      end
      S_ACK: begin
        if (!stat.ack_more) state_next = S_PAD;
      end
      S_PAD: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (rsp_ready && !stat.more) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl.op    = OP_NONE;
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) ctl.op = OP_LATCH;
      end
      S_DECODE: begin
        case (stat.action)
          ACT_PKT_READY:  ctl.op = OP_PKT;
          ACT_PHYS_READY: ctl.op = OP_PHYS;
          ACT_FRAME_RX:   ctl.op = stat.frame_ok ? OP_NONE : OP_BAD_FRAME;
          ACT_DATA_TMO:   ctl.op = OP_DATA_TMO;
          ACT_ACK_TMO:    ctl.op = OP_ACK_TMO;
          default:        ctl.op = OP_NONE;
        endcase
      end
      S_RX_HEAD: begin
        ctl.op = OP_RX_HEAD;
      end
      S_STORE: begin
        ctl.op = OP_STORE;
      end
      S_DELIVER: begin
        if (stat.deliver_more) ctl.op = OP_DELIVER;
      end
      S_NAK_RESEND: begin
        ctl.op = OP_NAK_RESEND;
      end
      S_ACK: begin
        if (stat.ack_more) ctl.op = OP_ACK_STEP;
      end
      S_PAD: begin
        ctl.op = OP_PAD;
      end
      S_LOAD: begin
        ctl.op = OP_LOAD;
      end
      S_DRAIN: begin
        rsp_valid = 1'b1;
        if (rsp_ready && stat.more) ctl.op = OP_LOAD;
      end
      default: begin
      end
    endcase
  end

  `SRARQ_ASSERT_NOW(a_one_side, req_ready, !rsp_valid)
  `SRARQ_ASSERT_NEXT(a_last_beat, rsp_valid && rsp_ready && !stat.more, req_ready)
  `SRARQ_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state == S_DECODE)

endmodule

`default_nettype wire

// ===== src/selective_repeat_arq_window_unit.sv =====
// Path: an accepted event passes decode, then pad and load before its first
//   beat; a good frame first runs the ack loop, a NAK frame after its resend
//   state, a data frame after its head state and, if stored, store and deliver.
// Throughput: one command beat per cycle while taken; the next event is taken
//   the cycle after the last beat.
// Reset: windows and flags return to their initial values at once (no sweep).
// ----------------------------------------------------------------------------
// selective_repeat_arq_window_unit
// Selective-repeat ARQ window control: one link event in, a burst of ordered
// link commands out.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_arq_window_unit
  import srarq_pkg::*;
#(
  parameter int SEQ_W = 3
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  wire  rsp_ready,
  output rsp_t rsp
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // Sequencer
  srarq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Window state and command queue
  srarq_dpath #(
    .SEQ_W (SEQ_W)
  ) u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire
